[src/bmp2pg_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, action codes and controller/datapath command types
// for the bitmap to page buffer block. No dependencies.
package bmp2pg_pkg;

  // Default geometry
  localparam int IMAGE_ROWS_DEF    = 64;
  localparam int BYTES_PER_ROW_DEF = 16;
  localparam int ROWS_PER_PAGE     = 8;
  localparam logic [7:0] ROW_BIT_LSB = 8'h01;

  // Action codes carried in the request transaction
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic clr_we;    // write zero at clear pointer, advance pointer
    logic latch;     // capture request payload
    logic restart;   // zero frame position
    logic wr_step;   // issue one read-modify-write read, next column
    logic advance;   // step frame position after a write
    logic rd_issue;  // read buffer at latched page/column
    logic out_load;  // load response register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;  // clear pointer at last entry
    logic k_last;    // column step at last of eight
  } dp_sts_t;

endpackage

[src/bmp2pg_req_if.sv]
`timescale 1ns / 1ps
// Request channel: valid/ready plus action and payload fields.
// No dependencies.
interface bmp2pg_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] image_byte;
  logic [2:0] read_page;
  logic [6:0] read_column;

  modport source (output valid, action, image_byte, read_page, read_column,
                  input ready);
  modport sink   (input valid, action, image_byte, read_page, read_column,
                  output ready);
endinterface

[src/bmp2pg_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: valid/ready plus read data.
// No dependencies.
interface bmp2pg_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

[src/bmp2pg_dp.sv]
`timescale 1ns / 1ps
// Datapath: page buffer memory, frame position counters, clear pointer,
// read-modify-write pipe and response register. Uses bmp2pg_pkg.
module bmp2pg_dp #(
  parameter int IMAGE_ROWS    = bmp2pg_pkg::IMAGE_ROWS_DEF,
  parameter int BYTES_PER_ROW = bmp2pg_pkg::BYTES_PER_ROW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bmp2pg_pkg::dp_cmd_t  cmd,
  output bmp2pg_pkg::dp_sts_t  sts,
  input  logic [7:0]           image_byte,
  input  logic [2:0]           read_page,
  input  logic [6:0]           read_column,
  output logic [7:0]           read_data
);

  localparam int PAGES   = (IMAGE_ROWS + bmp2pg_pkg::ROWS_PER_PAGE - 1) /
                           bmp2pg_pkg::ROWS_PER_PAGE;
  localparam int COLUMNS = BYTES_PER_ROW * 8;
  localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BYTE_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int COL_W   = BYTE_W + 3;
  localparam int RPOS_W  = PG_W + 3;
  localparam int ADDR_W  = PG_W + COL_W;
  localparam int DEPTH   = 1 << ADDR_W;

  logic [7:0]        mem [DEPTH];

  logic [ADDR_W-1:0] clr_ptr;
  logic [RPOS_W-1:0] row_pos;
  logic [BYTE_W-1:0] byte_pos;
  logic [2:0]        k;
  logic [7:0]        pixels;
  logic [PG_W-1:0]   rd_page;
  logic [COL_W-1:0]  rd_col;
  logic              rd_ok;
  logic              rmw_valid;
  logic              rmw_bit;
  logic [ADDR_W-1:0] rmw_addr;
  logic [2:0]        rmw_row;
  logic [7:0]        rdata;
  logic [7:0]        out_data;

  logic [31:0]       page_ext;
  logic [31:0]       col_ext;
  logic [ADDR_W-1:0] raddr;
  logic              re;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [7:0]        row_mask;

  assign page_ext = 32'(read_page);
  assign col_ext  = 32'(read_column);

  always_comb begin
    raddr = {rd_page, rd_col};
    if (cmd.wr_step) begin
      raddr = {row_pos[RPOS_W-1:3], byte_pos, k};
    end
  end
  assign re = cmd.wr_step | cmd.rd_issue;

  // Set or clear the row bit in the byte read in the previous cycle
  assign row_mask = bmp2pg_pkg::ROW_BIT_LSB << rmw_row;
  always_comb begin
    we    = 1'b0;
    waddr = rmw_addr;
    wdata = rmw_bit ? (rdata | row_mask) : (rdata & ~row_mask);
    if (cmd.clr_we) begin
      we    = 1'b1;
      waddr = clr_ptr;
      wdata = 8'h00;
    end else if (rmw_valid) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr   <= '0;
      row_pos   <= '0;
      byte_pos  <= '0;
      k         <= '0;
      rmw_valid <= 1'b0;
    end else begin
      rmw_valid <= cmd.wr_step;
      if (cmd.clr_we) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (cmd.wr_step) begin
        k <= k + 3'd1;
      end
      if (cmd.restart) begin
        row_pos  <= '0;
        byte_pos <= '0;
      end else if (cmd.advance) begin
        if (byte_pos == BYTE_W'(BYTES_PER_ROW - 1)) begin
          byte_pos <= '0;
          if (row_pos == RPOS_W'(IMAGE_ROWS - 1)) begin
            row_pos <= '0;
          end else begin
            row_pos <= row_pos + 1'b1;
          end
        end else begin
          byte_pos <= byte_pos + 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pixels  <= image_byte;
      rd_page <= page_ext[PG_W-1:0];
      rd_col  <= col_ext[COL_W-1:0];
      rd_ok   <= (page_ext < 32'(PAGES)) && (col_ext < 32'(COLUMNS));
    end
    if (cmd.wr_step) begin
      rmw_addr <= raddr;
      rmw_bit  <= pixels[3'd7 - k];
      rmw_row  <= row_pos[2:0];
    end
    if (cmd.out_load) begin
      out_data <= rd_ok ? rdata : 8'h00;
    end
  end

  assign sts.clr_last = (clr_ptr == {ADDR_W{1'b1}});
  assign sts.k_last   = (k == 3'd7);
  assign read_data    = out_data;

endmodule

[src/bmp2pg_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences buffer clear, write, read and restart transactions
// and owns both channel handshakes. Uses bmp2pg_pkg.
module bmp2pg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [1:0]           req_action,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output bmp2pg_pkg::dp_cmd_t  cmd,
  input  bmp2pg_pkg::dp_sts_t  sts
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_WRITE  = 6'b000100,
    ST_WDRAIN = 6'b001000,
    ST_READ   = 6'b010000,
    ST_RWAIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_full;
  logic   rsp_full_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch = 1'b1;
          case (req_action)
            bmp2pg_pkg::ACT_WRITE:   state_next = ST_WRITE;
            bmp2pg_pkg::ACT_READ:    state_next = ST_READ;
            bmp2pg_pkg::ACT_RESTART: cmd.restart = 1'b1;
            default:                 state_next = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.k_last) begin
          state_next = ST_WDRAIN;
        end
      end
      ST_WDRAIN: begin
        cmd.advance = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (!rsp_full || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    rsp_full_next = rsp_full;
    if (cmd.out_load) begin
      rsp_full_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      rsp_full <= 1'b0;
    end else begin
      state    <= state_next;
      rsp_full <= rsp_full_next;
    end
  end

  assign rsp_valid = rsp_full;

  a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_full || rsp_ready))
    else $error("response register loaded while holding an untaken result");

  a_write_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_action == bmp2pg_pkg::ACT_WRITE)
      |=> state == ST_WRITE)
    else $error("accepted write did not start the column sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && sts.k_last) |=> (state == ST_WDRAIN))
    else $error("column sweep did not end after eight steps");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!req_ready && !rsp_full))
    else $error("transaction activity during buffer clear");

endmodule

[src/bitmap_to_page_buffer_top.sv]
`timescale 1ns / 1ps
// Top level of the bitmap to page buffer block: controller plus datapath.
// Uses bmp2pg_pkg, bmp2pg_req_if, bmp2pg_rsp_if, bmp2pg_ctrl, bmp2pg_dp.

// Takes a row-major 1 bit/pixel image one byte per write transaction
// (bit 7 = leftmost pixel) and stores it transposed into a page buffer:
// a page is 8 rows, each column byte holds bit k for row k of its page.
// A write updates the eight column bytes by read-modify-write through the
// one write port of the buffer memory, one byte per cycle, and a drain
// state then retires the last write before the next request is taken. A
// read issues, does a registered memory read and loads the response
// register; reads outside the buffer return zero. A restart, or an unused
// action code, is taken without leaving the idle state. The response
// register decouples the channels, so a new request is taken while a read
// result still waits; a second read then waits only in its load step until
// the first result is taken. After reset the buffer is zeroed by a clearing
// pass of one entry per cycle over 2^(page bits + column bits) entries,
// which is 1024 with the default 64 x 128 image; no request is taken meanwhile.
module bitmap_to_page_buffer_top #(
  parameter int IMAGE_ROWS    = bmp2pg_pkg::IMAGE_ROWS_DEF,     // 8..256
  parameter int BYTES_PER_ROW = bmp2pg_pkg::BYTES_PER_ROW_DEF   // 1..64
) (
  input  logic       clk,
  input  logic       rst,
  bmp2pg_req_if.sink   req,
  bmp2pg_rsp_if.source rsp
);

  bmp2pg_pkg::dp_cmd_t cmd;
  bmp2pg_pkg::dp_sts_t sts;

  // Sequencing and handshakes
  bmp2pg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Buffer memory, frame position and response data
  bmp2pg_dp #(
    .IMAGE_ROWS    (IMAGE_ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .image_byte  (req.image_byte),
    .read_page   (req.read_page),
    .read_column (req.read_column),
    .read_data   (rsp.read_data)
  );

endmodule
